[sv/ws2f_pkg.sv]
// Package with shared format codes and widths for the sample-to-float32 converter.
`default_nettype none
package ws2f_pkg;
  localparam int RawW = 64;
  localparam int FltW = 32;
  localparam int FmtW = 3;

  typedef enum logic [FmtW-1:0] {
    FMT_PCM8  = 3'd0,
    FMT_PCM16 = 3'd1,
    FMT_PCM24 = 3'd2,
    FMT_PCM32 = 3'd3,
    FMT_F32   = 3'd4,
    FMT_F64   = 3'd5
  } fmt_t;

  localparam logic [FmtW-1:0] FmtReset = FMT_PCM16;
endpackage
`default_nettype wire

[sv/ws2f_if.sv]
// Valid/ready channel interfaces for raw samples and float results.
`default_nettype none
interface ws2f_raw_if;
  logic                 valid;
  logic                 ready;
  logic [63:0]          raw_sample;
  modport source (output valid, output raw_sample, input ready);
  modport sink   (input valid, input raw_sample, output ready);
endinterface

interface ws2f_flt_if;
  logic                 valid;
  logic                 ready;
  logic [31:0]          float_bits;
  modport source (output valid, output float_bits, input ready);
  modport sink   (input valid, input float_bits, output ready);
endinterface
`default_nettype wire

[sv/wave_sample_to_float32.sv]
// Each transaction passes through the input register and then the result register.
// Throughput: one transaction per cycle while the output is not stalled; the result register is refilled as it drains.
// The conversion is one pass of priority encode, shift and round between the two registers.
// Reset (rst_n low, synchronous) empties both stages and sets the format to pcm16.
// Configuration writes are taken in any cycle and apply to items entering the input register.
`default_nettype none
module wave_sample_to_float32
  import ws2f_pkg::*;
(
  input  wire logic            clk,
  input  wire logic            rst_n,
  ws2f_raw_if.sink             in_ch,
  ws2f_flt_if.source           out_ch,
  input  wire logic            cfg_we,
  input  wire logic [FmtW-1:0] cfg_wdata
);

  logic [FmtW-1:0] fmt_r;
  logic            s1_vld_r;
  logic [RawW-1:0] s1_raw_r;
  logic [FmtW-1:0] s1_fmt_r;
  logic            o_vld_r;
  logic [FltW-1:0] o_bits_r;
  logic [FltW-1:0] o_bits_nxt;

  // The pipeline advances whenever the result slot is empty or being taken.
  logic adv;
  assign adv         = !o_vld_r || out_ch.ready;
  assign in_ch.ready = adv;
  assign out_ch.valid      = o_vld_r;
  assign out_ch.float_bits = o_bits_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fmt_r    <= FmtReset;
      s1_vld_r <= 1'b0;
      o_vld_r  <= 1'b0;
    end else begin
      if (cfg_we) fmt_r <= cfg_wdata;
      if (adv) begin
        s1_vld_r <= in_ch.valid;
        o_vld_r  <= s1_vld_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_raw_r <= in_ch.raw_sample;
      s1_fmt_r <= fmt_r;
      o_bits_r <= o_bits_nxt;
    end
  end

  // Magnitude, sign and scale exponent for the shared packer. A value is mag * 2^e.
  logic        sgn;
  logic [63:0] mag;
  logic signed [12:0] ex;
  logic        pass;
  logic [FltW-1:0] pass_bits;
  logic signed [32:0] v32;

  always_comb begin
    sgn = 1'b0; mag = '0; ex = '0; pass = 1'b0; pass_bits = '0; v32 = '0;
    case (s1_fmt_r)
      FMT_PCM8: begin
        v32 = {25'd0, s1_raw_r[7:0]} - 33'sd128;
        ex  = -13'sd7;
      end
      FMT_PCM16: begin
        v32 = {{17{s1_raw_r[15]}}, s1_raw_r[15:0]};
        ex  = -13'sd15;
      end
      FMT_PCM24: begin
        v32 = {{9{s1_raw_r[23]}}, s1_raw_r[23:0]};
        ex  = -13'sd23;
      end
      FMT_PCM32: begin
        v32 = {s1_raw_r[31], s1_raw_r[31:0]};
        ex  = -13'sd31;
      end
      FMT_F32: begin
        pass = 1'b1; pass_bits = s1_raw_r[31:0];
      end
      FMT_F64: begin
        sgn = s1_raw_r[63];
        if (s1_raw_r[62:52] == 11'h7FF) begin
          pass = 1'b1;
          if (s1_raw_r[51:0] == '0) pass_bits = {sgn, 31'h7F800000};
          else pass_bits = {sgn, 31'h7FC00000} | {10'd0, s1_raw_r[50:29]};
        end else if (s1_raw_r[62:52] == '0) begin
          mag = {12'd0, s1_raw_r[51:0]};
          ex  = -13'sd1074;
        end else begin
          mag = {11'd0, 1'b1, s1_raw_r[51:0]};
          ex  = $signed({2'b00, s1_raw_r[62:52]}) - 13'sd1075;
        end
      end
      default: begin
        pass = 1'b1; pass_bits = '0;
      end
    endcase
    if (!pass && s1_fmt_r != FMT_F64) begin
      sgn = v32[32];
      mag = {31'd0, sgn ? 33'(-v32) : v32};
    end
  end

  // Packer: find the leading one, shift to 24 bits (or to the subnormal floor), round.
  logic [5:0]  lead;
  logic signed [13:0] sh, fl;
  logic [63:0] q, rem, half;
  logic        up;
  logic signed [15:0] bexp;
  logic [31:0] body;

  always_comb begin
    lead = '0;
    for (int i = 0; i < 64; i++) if (mag[i]) lead = 6'(i);
    sh = $signed({8'd0, lead}) - 14'sd23;
    fl = -14'sd149 - 14'(ex);
    if (fl > sh) sh = fl;
    q = '0; rem = '0; half = '0; up = 1'b0;
    if (sh <= 0) begin
      q = mag << 6'(-sh);
    end else if (sh >= 64) begin
      q = (sh == 64 && mag > 64'h8000000000000000) ? 64'd1 : 64'd0;
    end else begin
      half = 64'd1 << 6'(sh - 1);
      rem  = mag & ((half << 1) - 64'd1);
      q    = mag >> 6'(sh);
      up   = (rem > half) || (rem == half && q[0]);
      q    = q + {63'd0, up};
    end
    bexp = 16'(sh) + 16'(ex) + 16'sd149;
    body = {bexp[8:0], 23'd0} + q[31:0];
    if (pass)            o_bits_nxt = pass_bits;
    else if (mag == '0)  o_bits_nxt = {sgn, 31'd0};
    else if (body >= 32'h7F800000 || bexp > 16'sd255)
                         o_bits_nxt = {sgn, 31'h7F800000};
    else                 o_bits_nxt = {sgn, body[30:0]};
  end

`ifndef SYNTH
  // A result held under backpressure must not change.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.float_bits))
    else $error("result changed while stalled");
  // An accepted transaction passes through the input register into the result register when unstalled.
  a_flow: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready ##1 out_ch.ready |=> out_ch.valid)
    else $error("accepted transaction lost");
`endif

endmodule
`default_nettype wire

[bench/wave_sample_to_float32_tb.sv]
// Self-checking testbench for the raw audio sample to float32 converter.
`timescale 1ns / 100ps
module wave_sample_to_float32_tb;
  import ws2f_pkg::*;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [FmtW-1:0] cfg_wdata;

  ws2f_raw_if in_ch ();
  ws2f_flt_if out_ch ();

  wave_sample_to_float32 uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_ch(in_ch),
    .out_ch(out_ch),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  // Samples that are waiting to be driven, and float patterns still owed by the block.
  logic [63:0] pending_samples[$];
  logic [31:0] expected_floats[$];

  // The format the converter holds; the predictor follows it at each write.
  logic [FmtW-1:0] cur_format;

  // Idle percentages for both sides, and the long receiver hold-off count.
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  int unsigned hold_cycles;
  int unsigned error_count;

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Round mag * 2^e to single precision, nearest even, with gradual underflow.
  function automatic logic [31:0] round_single(input logic sgn, input logic [63:0] mag,
                                               input int e);
    int top;
    int sh;
    logic [63:0] q;
    logic [63:0] rem;
    logic [63:0] half;
    longint enc;
    logic [31:0] sbit;
    sbit = sgn ? 32'h8000_0000 : 32'h0;
    if (mag == 64'd0) return sbit;
    top = 63;
    while (mag[top] == 1'b0) top--;
    sh = top - 23;
    if (-149 - e > sh) sh = -149 - e;
    if (sh <= 0) begin
      q = mag << (-sh);
    end else if (sh >= 64) begin
      q = (sh == 64 && mag > 64'h8000_0000_0000_0000) ? 64'd1 : 64'd0;
    end else begin
      rem = mag & ((64'd1 << sh) - 64'd1);
      half = 64'd1 << (sh - 1);
      q = mag >> sh;
      if (rem > half || (rem == half && q[0])) q++;
    end
    enc = longint'(sh + e + 149) * 64'sd8388608 + longint'(q);
    if (enc >= 64'sh7F80_0000) return sbit | 32'h7F80_0000;
    return sbit | enc[31:0];
  endfunction

  // Converts a signed integer scaled by 2^e.
  function automatic logic [31:0] scale_signed(input longint v, input int e);
    if (v < 0) return round_single(1'b1, 64'(-v), e);
    return round_single(1'b0, 64'(v), e);
  endfunction

  // Narrows a double bit pattern, keeping infinities and quieting NaNs.
  function automatic logic [31:0] narrow_f64(input logic [63:0] d);
    logic [10:0] ex;
    logic [51:0] frac;
    ex = d[62:52];
    frac = d[51:0];
    if (ex == 11'h7FF) begin
      if (frac == 52'd0) return {d[63], 31'h7F80_0000};
      return {d[63], 31'h7FC0_0000} | 32'(frac >> 29);
    end
    if (ex == 11'd0) return round_single(d[63], 64'(frac), -1074);
    return round_single(d[63], {11'd0, 1'b1, frac}, int'(ex) - 1075);
  endfunction

  function automatic logic [31:0] convert_sample(input logic [FmtW-1:0] fmt,
                                                 input logic [63:0] raw);
    case (fmt)
      FMT_PCM8:  return scale_signed(longint'(raw[7:0]) - 128, -7);
      FMT_PCM16: return scale_signed(longint'($signed(raw[15:0])), -15);
      FMT_PCM24: return scale_signed(longint'($signed(raw[23:0])), -23);
      FMT_PCM32: return scale_signed(longint'($signed(raw[31:0])), -31);
      FMT_F32:   return raw[31:0];
      FMT_F64:   return narrow_f64(raw);
      default:   return 32'd0;
    endcase
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch %s: got %08h expected %08h", what, got, want);
    error_count++;
  endtask

  // The driver offers the head of the queue; the prediction is made when the
  // transaction is accepted, so it always uses the format in force then.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        expected_floats.push_back(convert_sample(cur_format, in_ch.raw_sample));
        void'(pending_samples.pop_front());
      end
      // Keep valid high while the current item is still waiting, else decide anew.
      // The accepted item has already left the queue, so the head is the next one.
      if (in_ch.valid && !in_ch.ready) begin
      end else if (pending_samples.size() > 0 &&
                   $urandom_range(99) >= send_idle_pct) begin
        in_ch.valid <= 1'b1;
        in_ch.raw_sample <= pending_samples[0];
      end else begin
        in_ch.valid <= 1'b0;
        in_ch.raw_sample <= {$urandom, $urandom};
      end
    end
  end

  // The monitor checks each result transaction against the oldest prediction and
  // stalls at random, or for the whole of a long hold-off.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_floats.size() == 0) begin
          report_mismatch("unexpected result", out_ch.float_bits, 32'd0);
        end else begin
          if (out_ch.float_bits !== expected_floats[0])
            report_mismatch("float_bits", out_ch.float_bits, expected_floats[0]);
          void'(expected_floats.pop_front());
        end
      end
      if (hold_cycles > 0) begin
        hold_cycles <= hold_cycles - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // Waits until every item has gone in and every result has come out, then lets
  // the pipeline settle before the format changes.
  task automatic drain_block();
    while (pending_samples.size() != 0 || in_ch.valid || expected_floats.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_format(input logic [FmtW-1:0] fmt);
    cfg_we <= 1'b1;
    cfg_wdata <= fmt;
    @(posedge clk);
    cfg_we <= 1'b0;
    cur_format = fmt;
  endtask

  // Builds a random sample that suits the format: extremes, NaNs, tiny and huge
  // doubles, and plain noise in the bytes above the sample.
  function automatic logic [63:0] random_sample(input logic [FmtW-1:0] fmt);
    logic [63:0] r;
    r = {$urandom, $urandom};
    if (fmt == FMT_F64) begin
      case ($urandom_range(5))
        0: r[62:52] = 11'h7FF;
        1: r[62:52] = 11'd0;
        2: r[62:52] = 11'(1023 - 150 + $urandom_range(30));
        3: r[62:52] = 11'(1023 + 120 + $urandom_range(15));
        default: r[62:52] = 11'(1023 - 30 + $urandom_range(60));
      endcase
      if ($urandom_range(7) == 0) r[28:0] = 29'h1000_0000;
    end else if ($urandom_range(9) == 0) begin
      r[31:0] = ($urandom_range(1)) ? 32'h0 : 32'hFFFF_FFFF;
    end
    return r;
  endfunction

  task automatic run_phase(input logic [FmtW-1:0] fmt, input int n, input int unsigned sidle,
                           input int unsigned rstall);
    drain_block();
    write_format(fmt);
    send_idle_pct = sidle;
    recv_stall_pct = rstall;
    for (int i = 0; i < n; i++) pending_samples.push_back(random_sample(fmt));
  endtask

  initial begin
    logic [FmtW-1:0] fmt_cycle[8];
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    in_ch.valid = 1'b0;
    in_ch.raw_sample = '0;
    out_ch.ready = 1'b0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_cycles = 0;
    error_count = 0;
    cur_format = FmtReset;
    fmt_cycle = '{FMT_PCM8, FMT_PCM16, FMT_PCM24, FMT_PCM32, FMT_F32, FMT_F64,
                  3'd6, 3'd7};
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part: reset format first, then the extremes of each format.
    pending_samples.push_back(64'hFFFF_FFFF_FFFF_8000);
    pending_samples.push_back(64'h0000_0000_0000_7FFF);
    pending_samples.push_back(64'h1234_5678_9ABC_0000);
    drain_block();
    write_format(FMT_PCM8);
    pending_samples.push_back(64'h0);
    pending_samples.push_back(64'hFFFF_FFFF_FFFF_FF80);
    pending_samples.push_back(64'hFF);
    drain_block();
    write_format(FMT_PCM24);
    pending_samples.push_back(64'h80_0000);
    pending_samples.push_back(64'hFFFF_FFFF_FF7F_FFFF);
    drain_block();
    write_format(FMT_PCM32);
    pending_samples.push_back(64'h8000_0000);
    pending_samples.push_back(64'h7FFF_FFFF);
    pending_samples.push_back(64'h0000_0001);
    drain_block();
    write_format(FMT_F32);
    pending_samples.push_back(64'hDEAD_BEEF_7FC0_0001);
    pending_samples.push_back(64'hFFFF_FFFF);
    drain_block();
    write_format(FMT_F64);
    pending_samples.push_back(64'h7FF0_0000_0000_0000);  // plus infinity
    pending_samples.push_back(64'hFFF0_0000_0000_0001);  // signaling NaN, negative
    pending_samples.push_back(64'h7FEF_FFFF_FFFF_FFFF);  // overflows to infinity
    pending_samples.push_back(64'h0000_0000_0000_0001);  // underflows to zero
    pending_samples.push_back(64'h36A0_0000_0000_0000);  // the least subnormal
    pending_samples.push_back(64'h8000_0000_0000_0000);  // negative zero
    pending_samples.push_back(64'h3FF0_0000_1000_0000);  // tie, rounds to even
    drain_block();
    write_format(3'd6);
    pending_samples.push_back(64'hFFFF_FFFF_FFFF_FFFF);
    drain_block();
    write_format(3'd7);
    pending_samples.push_back(64'h0123_4567_89AB_CDEF);

    // Long receiver hold-off while the sender keeps offering, so the input stalls.
    run_phase(FMT_PCM16, 40, 0, 0);
    hold_cycles = 60;
    // Random part over every format and every idling mix.
    for (int p = 0; p < 32; p++) begin
      case (p % 4)
        0: run_phase(fmt_cycle[p % 8], 24, 0, 0);
        1: run_phase(fmt_cycle[(p * 3) % 8], 24, 70, 0);
        2: run_phase(fmt_cycle[(p * 5) % 8], 24, 0, 70);
        default: run_phase(fmt_cycle[(p * 7) % 8], 24, 31, 31);
      endcase
    end
    drain_block();
    repeat (10) @(posedge clk);
    if (error_count == 0)
      $display("PASS wave_sample_to_float32");
    else
      $display("FAIL wave_sample_to_float32");
    $finish;
  end

  // Generous overall limit for the slowest correct run.
  initial begin
    #2_000_000;
    $display("FAIL wave_sample_to_float32");
    $finish;
  end
endmodule
